[rtl/core/lslf_pkg.sv]
// Package: shared constants, widths, status codes and the arctangent table.
package lslf_pkg;
    localparam int CoordW       = 20;
    localparam int AngleW       = 16;
    localparam int StatusW      = 2;
    localparam int MaxPointsDef = 1024;
    localparam int CordicDef    = 16;
    localparam int AtanLen      = 24;
    localparam logic signed [AngleW-1:0] HalfPiQ13 = 16'sd12868;

    typedef enum logic [StatusW-1:0] {
        ST_OK       = 2'd0,
        ST_VERTICAL = 2'd1,
        ST_TOO_FEW  = 2'd2
    } t_status;

    function automatic logic [AngleW-1:0] atan_step(input logic [4:0] i);
        logic [AngleW-1:0] r;
        begin
            case (i)
                5'd0:  r = 16'd6434;
                5'd1:  r = 16'd3798;
                5'd2:  r = 16'd2007;
                5'd3:  r = 16'd1019;
                5'd4:  r = 16'd511;
                5'd5:  r = 16'd256;
                5'd6:  r = 16'd128;
                5'd7:  r = 16'd64;
                5'd8:  r = 16'd32;
                5'd9:  r = 16'd16;
                5'd10: r = 16'd8;
                5'd11: r = 16'd4;
                5'd12: r = 16'd2;
                5'd13: r = 16'd1;
                default: r = '0;
            endcase
            return r;
        end
    endfunction
endpackage

[rtl/core/lslf_point_if.sv]
// Interfaces: point input channel and fit result channel.
interface lslf_point_if;
    logic valid;
    logic ready;
    logic signed [19:0] point_x;
    logic signed [19:0] point_y;
    logic last_point;
    modport source (output valid, point_x, point_y, last_point, input ready);
    modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

interface lslf_fit_if;
    logic valid;
    logic ready;
    logic signed [15:0] angle;
    logic signed [19:0] centroid_x;
    logic signed [19:0] centroid_y;
    logic [1:0] status;
    modport source (output valid, angle, centroid_x, centroid_y, status, input ready);
    modport sink   (input valid, angle, centroid_x, centroid_y, status, output ready);
endinterface

[rtl/core/least_squares_line_fit.sv]
// Top level: point store, centroid divider, centred-sum pass and CORDIC angle.
//
//  channel   dir  signals                                    beat
//  i_pt      in   point_x, point_y, last_point               one point
//  o_fit     out  angle, centroid_x, centroid_y, status      one fit
//
// The last point starts the fit: two restoring divides share one unit, the
// second pass steps through each point (RAM read, read wait, two products
// through one multiplier), then the CORDIC steps run (none if Sxx is zero)
// and the output state follows.
// Reset is synchronous and clears control only; no clearing pass is needed.
// A stalled result holds in the output register; no point is taken meanwhile.
module least_squares_line_fit #(
    parameter int MAX_POINTS   = lslf_pkg::MaxPointsDef,
    parameter int CORDIC_STEPS = lslf_pkg::CordicDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lslf_point_if.sink        i_pt,
    lslf_fit_if.source        o_fit
);
    import lslf_pkg::*;

    localparam int AW   = $clog2(MAX_POINTS);
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int SW   = CoordW + CW;            // coordinate sum
    localparam int DW   = CoordW + 2;             // centred difference
    localparam int PW   = 2 * DW;                 // product
    localparam int AccW = PW + CW;                // centred sum
    localparam int XW   = AccW + 2;               // CORDIC datapath
    localparam int NSteps = (CORDIC_STEPS > AtanLen) ? AtanLen : CORDIC_STEPS;
    localparam int KW   = $clog2(AtanLen + 1);
    localparam int QW   = (SW > 6) ? $clog2(SW + 1) : 3;

    typedef enum logic [7:0] {
        S_LOAD  = 8'b0000_0001,
        S_DIVX  = 8'b0000_0010,
        S_DIVY  = 8'b0000_0100,
        S_RD    = 8'b0000_1000,
        S_MULXX = 8'b0001_0000,
        S_MULXY = 8'b0010_0000,
        S_CORD  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic signed [SW-1:0] r_sum_x, n_sum_x, r_sum_y, n_sum_y;
    logic [AW-1:0] r_idx, n_idx;
    logic [QW-1:0] r_dstep, n_dstep;
    logic [SW-1:0] r_quo, n_quo, r_rem, n_rem;
    logic signed [CoordW-1:0] r_cx, n_cx, r_cy, n_cy;
    logic signed [DW-1:0] r_dx, n_dx, r_dy, n_dy;
    logic signed [AccW-1:0] r_sxx, n_sxx, r_sxy, n_sxy;
    logic signed [XW-1:0] r_cx_w, n_cx_w, r_cy_w, n_cy_w;
    logic signed [AngleW-1:0] r_z, n_z;
    logic [KW-1:0] r_k, n_k;
    logic r_rd_valid, n_rd_valid;
    logic r_o_valid, n_o_valid;
    logic signed [AngleW-1:0] r_angle, n_angle;
    logic signed [CoordW-1:0] r_ocx, n_ocx, r_ocy, n_ocy;
    t_status r_status, n_status;

    logic ram_we;
    logic [AW-1:0] ram_addr;
    logic [2*CoordW-1:0] ram_rdata;
    logic accept, full;
    logic signed [PW-1:0] prod;
    logic signed [DW-1:0] mul_a, mul_b;
    logic [SW-1:0] div_num, div_trial;
    logic [SW:0] div_sub;
    logic div_neg;
    logic signed [XW-1:0] xs, ys;

    lslf_ram #(.Width(2 * CoordW), .Depth(MAX_POINTS)) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata({i_pt.point_y, i_pt.point_x}),
        .o_rdata(ram_rdata)
    );

    assign i_pt.ready = (r_state == S_LOAD) && !r_o_valid;
    assign accept     = i_pt.valid && i_pt.ready;
    assign full       = (r_count == CW'(MAX_POINTS));
    assign ram_we     = accept && !full;
    assign ram_addr   = (r_state == S_LOAD) ? r_count[AW-1:0] : r_idx;

    assign o_fit.valid      = r_o_valid;
    assign o_fit.angle      = r_angle;
    assign o_fit.centroid_x = r_ocx;
    assign o_fit.centroid_y = r_ocy;
    assign o_fit.status     = r_status;

    // shared multiplier
    assign mul_a = r_dx;
    assign mul_b = (r_state == S_MULXX) ? r_dx : r_dy;
    assign prod  = mul_a * mul_b;

    // shared restoring divider on the magnitude of the active sum
    assign div_neg   = (r_state == S_DIVX) ? r_sum_x[SW-1] : r_sum_y[SW-1];
    assign div_num   = (r_state == S_DIVX) ? (r_sum_x[SW-1] ? SW'(-r_sum_x) : r_sum_x)
                                           : (r_sum_y[SW-1] ? SW'(-r_sum_y) : r_sum_y);
    assign div_trial = {r_rem[SW-2:0], r_quo[SW-1]};
    assign div_sub   = {1'b0, div_trial} - {{(SW + 1 - CW){1'b0}}, r_count};

    assign xs = r_cx_w >>> r_k;
    assign ys = r_cy_w >>> r_k;

    always_comb begin
        n_state = r_state; n_count = r_count; n_sum_x = r_sum_x; n_sum_y = r_sum_y;
        n_idx = r_idx; n_dstep = r_dstep; n_quo = r_quo; n_rem = r_rem;
        n_cx = r_cx; n_cy = r_cy; n_dx = r_dx; n_dy = r_dy;
        n_sxx = r_sxx; n_sxy = r_sxy; n_cx_w = r_cx_w; n_cy_w = r_cy_w;
        n_z = r_z; n_k = r_k; n_rd_valid = 1'b0; n_o_valid = r_o_valid;
        n_angle = r_angle; n_ocx = r_ocx; n_ocy = r_ocy; n_status = r_status;
        if (r_o_valid && o_fit.ready) begin
            n_o_valid = 1'b0;
        end
        case (r_state)
            S_LOAD: begin
                if (accept) begin
                    if (!full) begin
                        n_count = r_count + CW'(1);
                        n_sum_x = r_sum_x + SW'(i_pt.point_x);
                        n_sum_y = r_sum_y + SW'(i_pt.point_y);
                    end
                    if (i_pt.last_point) begin
                        if (n_count < CW'(2)) begin
                            n_o_valid = 1'b1;
                            n_angle = '0; n_ocx = '0; n_ocy = '0;
                            n_status = ST_TOO_FEW;
                            n_count = '0; n_sum_x = '0; n_sum_y = '0;
                        end else begin
                            n_state = S_DIVX;
                            n_dstep = '0;
                            n_quo = '0; n_rem = '0;
                        end
                    end
                end
            end
            S_DIVX, S_DIVY: begin
                if (r_dstep == '0) begin
                    n_quo = div_num; n_rem = '0;
                    n_dstep = QW'(1);
                end else begin
                    // shift one numerator bit into the remainder, restore on borrow
                    if (!div_sub[SW]) begin
                        n_rem = div_sub[SW-1:0];
                        n_quo = {r_quo[SW-2:0], 1'b1};
                    end else begin
                        n_rem = div_trial;
                        n_quo = {r_quo[SW-2:0], 1'b0};
                    end
                    if (r_dstep == QW'(SW)) begin
                        n_dstep = '0;
                        if (r_state == S_DIVX) begin
                            n_cx = div_neg ? CoordW'(-n_quo) : CoordW'(n_quo);
                            n_state = S_DIVY;
                        end else begin
                            n_cy = div_neg ? CoordW'(-n_quo) : CoordW'(n_quo);
                            n_state = S_RD;
                            n_idx = '0; n_sxx = '0; n_sxy = '0;
                            n_rd_valid = 1'b0;
                        end
                    end else begin
                        n_dstep = r_dstep + QW'(1);
                    end
                end
            end
            S_RD: begin
                if (r_rd_valid) begin
                    n_dx = DW'(signed'(ram_rdata[CoordW-1:0])) - DW'(r_cx);
                    n_dy = DW'(signed'(ram_rdata[2*CoordW-1:CoordW])) - DW'(r_cy);
                    n_state = S_MULXX;
                end else begin
                    n_rd_valid = 1'b1;
                end
            end
            S_MULXX: begin
                n_sxx = r_sxx + AccW'(prod);
                n_state = S_MULXY;
            end
            S_MULXY: begin
                n_sxy = r_sxy + AccW'(prod);
                if (CW'(r_idx) == r_count - CW'(1)) begin
                    n_state = S_CORD;
                    n_cx_w = XW'(r_sxx); n_cy_w = XW'(n_sxy);
                    n_z = '0; n_k = '0;
                end else begin
                    n_idx = r_idx + AW'(1);
                    n_state = S_RD;
                end
            end
            S_CORD: begin
                if (r_sxx == '0) begin
                    n_state = S_OUT;
                end else if (r_k == KW'(NSteps)) begin
                    n_state = S_OUT;
                end else begin
                    if (!r_cy_w[XW-1]) begin
                        n_cx_w = r_cx_w + ys; n_cy_w = r_cy_w - xs;
                        n_z = r_z + AngleW'(atan_step(5'(r_k)));
                    end else begin
                        n_cx_w = r_cx_w - ys; n_cy_w = r_cy_w + xs;
                        n_z = r_z - AngleW'(atan_step(5'(r_k)));
                    end
                    n_k = r_k + KW'(1);
                end
            end
            S_OUT: begin
                if (!r_o_valid) begin
                    n_o_valid = 1'b1;
                    n_ocx = r_cx; n_ocy = r_cy;
                    if (r_sxx == '0) begin
                        n_angle = HalfPiQ13; n_status = ST_VERTICAL;
                    end else begin
                        n_angle = r_z; n_status = ST_OK;
                    end
                    n_count = '0; n_sum_x = '0; n_sum_y = '0;
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD; r_count <= '0; r_sum_x <= '0; r_sum_y <= '0;
            r_o_valid <= 1'b0; r_rd_valid <= 1'b0; r_dstep <= '0;
        end else begin
            r_state <= n_state; r_count <= n_count; r_sum_x <= n_sum_x;
            r_sum_y <= n_sum_y; r_o_valid <= n_o_valid; r_rd_valid <= n_rd_valid;
            r_dstep <= n_dstep;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx; r_quo <= n_quo; r_rem <= n_rem; r_cx <= n_cx; r_cy <= n_cy;
        r_dx <= n_dx; r_dy <= n_dy; r_sxx <= n_sxx; r_sxy <= n_sxy;
        r_cx_w <= n_cx_w; r_cy_w <= n_cy_w; r_z <= n_z; r_k <= n_k;
        r_angle <= n_angle; r_ocx <= n_ocx; r_ocy <= n_ocy; r_status <= n_status;
    end
endmodule

[rtl/core/lslf_ram.sv]
// Generic single-port RAM with registered read.
module lslf_ram #(
    parameter int Width = 40,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

[rtl/core/lslf_checker.sv]
// Checker: port-level properties of the line fit, bound to the top level.
module lslf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] angle,
    input logic [19:0] cx,
    input logic [19:0] cy,
    input logic [1:0]  status
);
    import lslf_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(angle) && $stable(status))
        else $error("stalled beat changed");
    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && in_valid |-> !in_ready)
        else $error("point taken while result pending");
    a_too_few_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && status == ST_TOO_FEW |-> angle == '0 && cx == '0 && cy == '0)
        else $error("too-few result not zeroed");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> status != 2'd3)
        else $error("bad status");
    a_vertical_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && status == ST_VERTICAL |-> angle == HalfPiQ13)
        else $error("vertical angle wrong");
endmodule

bind least_squares_line_fit lslf_checker u_lslf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .in_valid (i_pt.valid),
    .in_ready (i_pt.ready),
    .out_valid(o_fit.valid),
    .out_ready(o_fit.ready),
    .angle    (o_fit.angle),
    .cx       (o_fit.centroid_x),
    .cy       (o_fit.centroid_y),
    .status   (o_fit.status)
);
